FILE: hw/rtl/abc_pkg.sv
`default_nettype none
package abc_pkg;

  // field widths
  localparam int unsigned RateW = 20;
  localparam int unsigned LossW = 8;
  localparam int unsigned RunW  = 8;
  localparam int unsigned FuncW = 2;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = $clog2(NumCfg);

  // loss-free reports needed to leave congestion
  localparam logic [RunW-1:0] RunThreshold = RunW'(10);
  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSteadyMax    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSteadyMin    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgSteadyUp     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSteadyDown   = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgCongestMax   = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgCongestMin   = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] CfgCongestUp    = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgCongestDown  = CfgIdxW'(7);

  typedef logic [NumCfg-1:0][RateW-1:0] abc_cfg_t;

  // register reset values, entry 0 in the low slice
  localparam abc_cfg_t CfgReset = {
    RateW'(1000), RateW'(50),  RateW'(500), RateW'(4000),
    RateW'(500),  RateW'(200), RateW'(1000), RateW'(8000)
  };

  typedef enum logic [FuncW-1:0] {
    FuncReport  = 2'd0,
    FuncRestart = 2'd1,
    FuncFixed   = 2'd2
  } abc_func_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [LossW-1:0] loss_fraction;
    logic [RateW-1:0] encoder_rate;
    logic [RateW-1:0] estimated_rate;
    logic             sink_present;
    logic [RateW-1:0] preset_rate;
  } abc_item_t;

  typedef struct packed {
    logic [RateW-1:0] bitrate_now;
    logic             congested;
    logic [RunW-1:0]  good_run;
    logic             overflow_warning;
  } abc_result_t;

  typedef struct packed {
    logic             link_congested;
    logic             limits_congested;
    logic [RunW-1:0]  run_count;
    logic [RateW-1:0] current_rate;
  } abc_state_t;

  // take the candidate if it is valid and within limits, else clamp current
  function automatic logic [RateW-1:0] apply_rate(
    input logic [RateW:0]   cand,
    input logic             ok,
    input logic [RateW-1:0] cur,
    input logic [RateW-1:0] mx,
    input logic [RateW-1:0] mn
  );
    logic [RateW-1:0] res;
    if (ok && (cand >= {1'b0, mn}) && (cand <= {1'b0, mx})) begin
      res = cand[RateW-1:0];
    end else if (cur > mx) begin
      res = mx;
    end else if (cur < mn) begin
      res = mn;
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/abc_if.sv
`default_nettype none
// report request channel
interface abc_in_if;
  import abc_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [LossW-1:0]    loss_fraction;
  logic [RateW-1:0]    encoder_rate;
  logic [RateW-1:0]    estimated_rate;
  logic                sink_present;
  logic [RateW-1:0]    preset_rate;
  modport source (output valid, func, loss_fraction, encoder_rate, estimated_rate,
                  sink_present, preset_rate, input ready);
  modport sink (input valid, func, loss_fraction, encoder_rate, estimated_rate,
                sink_present, preset_rate, output ready);
endinterface

// result request channel
interface abc_out_if;
  import abc_pkg::*;
  logic                valid;
  logic                ready;
  logic [RateW-1:0]    bitrate_now;
  logic                congested;
  logic [RunW-1:0]     good_run;
  logic                overflow_warning;
  modport source (output valid, bitrate_now, congested, good_run, overflow_warning,
                  input ready);
  modport sink (input valid, bitrate_now, congested, good_run, overflow_warning,
                output ready);
endinterface

// register write channel
interface abc_cfg_if;
  import abc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [RateW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/abc_update.sv
`default_nettype none
module abc_update (
  input  abc_pkg::abc_cfg_t    cfg_i,
  input  abc_pkg::abc_state_t  state_i,
  input  abc_pkg::abc_item_t   item_i,
  output abc_pkg::abc_state_t  state_o,
  output abc_pkg::abc_result_t result_o
);
  import abc_pkg::*;

  logic             link_pre;
  logic             lim_sel;
  logic [RateW-1:0] mx, mn, up, dn;
  logic [RateW-1:0] cur_base;
  logic [RateW:0]   cand;
  logic             cand_ok;
  logic             warn;
  logic             lower;
  logic [RateW+1:0] enc_x2, est_x3;
  logic             do_apply;

  // overflow check: 2*enc >= 3*est, exact
  assign enc_x2 = {1'b0, item_i.encoder_rate, 1'b0};
  assign est_x3 = {2'b00, item_i.estimated_rate} + {1'b0, item_i.estimated_rate, 1'b0};

  assign link_pre = (state_i.run_count >= RunThreshold) ? 1'b0 : state_i.link_congested;

  // limit set selection
  always_comb begin
    mx = lim_sel ? cfg_i[CfgCongestMax]  : cfg_i[CfgSteadyMax];
    mn = lim_sel ? cfg_i[CfgCongestMin]  : cfg_i[CfgSteadyMin];
    up = lim_sel ? cfg_i[CfgCongestUp]   : cfg_i[CfgSteadyUp];
    dn = lim_sel ? cfg_i[CfgCongestDown] : cfg_i[CfgSteadyDown];
  end

  // command decode and next state
  always_comb begin
    state_o  = state_i;
    lim_sel  = state_i.limits_congested;
    cur_base = state_i.current_rate;
    warn     = 1'b0;
    lower    = 1'b0;
    do_apply = 1'b0;
    cand     = {1'b0, item_i.preset_rate};
    cand_ok  = 1'b1;
    unique case (abc_func_e'(item_i.func))
      FuncReport: begin
        lim_sel  = link_pre;
        do_apply = 1'b1;
        state_o.limits_congested = link_pre;
        if (item_i.loss_fraction == '0) begin
          state_o.link_congested = link_pre;
          if (state_i.run_count != RunMax) begin
            state_o.run_count = state_i.run_count + RunW'(1);
          end
          warn  = item_i.sink_present && (enc_x2 >= est_x3);
          lower = warn;
        end else begin
          state_o.link_congested = 1'b1;
          state_o.run_count      = '0;
          lower                  = 1'b1;
        end
        if (lower) begin
          cand_ok = (dn <= state_i.current_rate);
          cand    = {1'b0, state_i.current_rate - dn};
        end else begin
          cand    = {1'b0, state_i.current_rate} + {1'b0, up};
        end
      end
      FuncRestart: begin
        lim_sel  = 1'b0;
        cur_base = cfg_i[CfgSteadyMin];
        do_apply = 1'b1;
        state_o.link_congested   = 1'b0;
        state_o.limits_congested = 1'b0;
        state_o.run_count        = '0;
      end
      FuncFixed: begin
        do_apply = 1'b1;
      end
      default: begin
        do_apply = 1'b0;
      end
    endcase
    if (do_apply) begin
      state_o.current_rate = apply_rate(cand, cand_ok, cur_base, mx, mn);
    end
  end

  assign result_o.bitrate_now      = state_o.current_rate;
  assign result_o.congested        = state_o.link_congested;
  assign result_o.good_run         = state_o.run_count;
  assign result_o.overflow_warning = warn;

endmodule
`default_nettype wire

FILE: hw/rtl/adaptive_bitrate_controller_unit.sv
// Adaptive bitrate controller.
// in_i carries QoS report and preset requests, out_o returns one result
// request per input request (bitrate, link state, run count, warning).
// cfg_i writes the eight limit and step registers; it is always ready and
// must only be used while no request is in flight.
// A request accepted on in_i is taken into the input register; the update
// pass then loads its result into the output register, and out_o shows it
// from then on. Throughput is one request per cycle while out_o is not
// stalled, set by the single update pass from input register to result
// register; the state registers are updated by that same pass.
// A stalled out_o holds its result; the input register still takes one
// more request, and in_i.ready drops while both registers are full.
// Reset clears the link state, run count and bitrate to zero and loads
// the registers with their default limits and steps.
`default_nettype none
module adaptive_bitrate_controller_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  abc_in_if.sink    in_i,
  abc_out_if.source out_o,
  abc_cfg_if.sink   cfg_i
);
  import abc_pkg::*;

  abc_cfg_t    cfg_q;
  abc_state_t  state_q, state_d;
  abc_item_t   in_q, in_item;
  logic        in_valid_q;
  abc_result_t out_q, result_d;
  logic        out_valid_q;
  logic        adv;

  // register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // handshake control
  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  assign in_item.func           = in_i.func;
  assign in_item.loss_fraction  = in_i.loss_fraction;
  assign in_item.encoder_rate   = in_i.encoder_rate;
  assign in_item.estimated_rate = in_i.estimated_rate;
  assign in_item.sink_present   = in_i.sink_present;
  assign in_item.preset_rate    = in_i.preset_rate;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_item;
    end
  end

  abc_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.bitrate_now      = out_q.bitrate_now;
  assign out_o.congested        = out_q.congested;
  assign out_o.good_run         = out_q.good_run;
  assign out_o.overflow_warning = out_q.overflow_warning;

  // a warning only comes from a loss-free report, so the run is nonzero
  a_warn_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow_warning |-> out_q.good_run != '0)
    else $error("overflow warning with empty run");

  // a held input request keeps its payload
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_q))
    else $error("input register lost a stalled request");

  // state moves only when a request is processed
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without a request");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import abc_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam logic [RateW-1:0] RateAll    = {RateW{1'b1}};
  localparam int unsigned      StallLimit = 4000;
  localparam int unsigned      NumPhases  = 10;
  localparam int unsigned      PhaseItems = 80;
  localparam int unsigned      LongRun    = 270;

  typedef enum int unsigned {
    LimWide, LimZero, LimCrossed, LimDefault, LimRandom
  } limit_profile_e;

  typedef enum int unsigned {
    SinkOpen, SinkCoin, SinkSparse, SinkPattern
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  abc_in_if  in_if ();
  abc_out_if out_if ();
  abc_cfg_if cfg_if ();

  adaptive_bitrate_controller_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of registers and controller state
  logic [RateW-1:0] rate_reg [NumCfg];
  logic             link_cong;
  logic             lim_cong;
  logic [RunW-1:0]  run_cnt;
  logic [RateW-1:0] cur_rate;

  abc_item_t   pending_reports [$];
  abc_result_t expected_updates [$];

  logic        report_taken = 1'b0;
  int unsigned queued       = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;

  // limit or step of the latched limit set
  function automatic logic [RateW-1:0] lim_sel(input logic [CfgIdxW-1:0] steady_idx,
                                               input logic [CfgIdxW-1:0] cong_idx);
    return lim_cong ? rate_reg[cong_idx] : rate_reg[steady_idx];
  endfunction

  // take candidate inside [min, max], else pull current rate into the limits
  function automatic void fit_rate(input logic [RateW:0] cand, input logic ok);
    logic [RateW-1:0] hi;
    logic [RateW-1:0] lo;
    hi = lim_sel(CfgSteadyMax, CfgCongestMax);
    lo = lim_sel(CfgSteadyMin, CfgCongestMin);
    if (ok && cand >= {1'b0, lo} && cand <= {1'b0, hi}) begin
      cur_rate = cand[RateW-1:0];
    end else if (cur_rate > hi) begin
      cur_rate = hi;
    end else if (cur_rate < lo) begin
      cur_rate = lo;
    end
  endfunction

  function automatic void step_down();
    logic [RateW-1:0] dn;
    dn = lim_sel(CfgSteadyDown, CfgCongestDown);
    // underflow counts as out of range
    if (dn > cur_rate) begin
      fit_rate('0, 1'b0);
    end else begin
      fit_rate({1'b0, cur_rate - dn}, 1'b1);
    end
  endfunction

  function automatic abc_result_t predict_bitrate(input abc_item_t it);
    abc_result_t      res;
    logic             warn;
    logic [RateW+1:0] enc2;
    logic [RateW+1:0] est3;
    warn = 1'b0;
    enc2 = {2'b0, it.encoder_rate} << 1;
    est3 = {2'b0, it.estimated_rate} + {1'b0, it.estimated_rate, 1'b0};
    case (it.func)
      FuncReport: begin
        if (run_cnt >= RunThreshold) begin
          link_cong = 1'b0;
        end
        lim_cong = link_cong;
        if (it.loss_fraction == '0) begin
          if (run_cnt != RunMax) begin
            run_cnt = run_cnt + 1'b1;
          end
          if (it.sink_present && enc2 >= est3) begin
            warn = 1'b1;
            step_down();
          end else begin
            fit_rate({1'b0, cur_rate} + {1'b0, lim_sel(CfgSteadyUp, CfgCongestUp)}, 1'b1);
          end
        end else begin
          link_cong = 1'b1;
          run_cnt   = '0;
          step_down();
        end
      end
      FuncRestart: begin
        link_cong = 1'b0;
        lim_cong  = 1'b0;
        cur_rate  = rate_reg[CfgSteadyMin];
        fit_rate({1'b0, it.preset_rate}, 1'b1);
        run_cnt   = '0;
      end
      FuncFixed: begin
        fit_rate({1'b0, it.preset_rate}, 1'b1);
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase
    res.bitrate_now      = cur_rate;
    res.congested        = link_cong;
    res.good_run         = run_cnt;
    res.overflow_warning = warn;
    return res;
  endfunction

  // monitor: register writes, result check, request prediction, watchdog
  always @(posedge clk_i) begin : monitor
    abc_result_t got;
    abc_result_t want;
    abc_item_t   it;
    logic        progress;
    progress = 1'b0;
    report_taken = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        rate_reg[cfg_if.index] = cfg_if.data;
        progress = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        progress             = 1'b1;
        got.bitrate_now      = out_if.bitrate_now;
        got.congested        = out_if.congested;
        got.good_run         = out_if.good_run;
        got.overflow_warning = out_if.overflow_warning;
        if (expected_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: rate %0d cong %0b run %0d warn %0b",
                     got.bitrate_now, got.congested, got.good_run, got.overflow_warning);
          end
        end else begin
          want = expected_updates.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected rate %0d cong %0b run %0d warn %0b",
                       want.bitrate_now, want.congested, want.good_run,
                       want.overflow_warning);
              $display("          actual   rate %0d cong %0b run %0d warn %0b",
                       got.bitrate_now, got.congested, got.good_run, got.overflow_warning);
            end
          end
        end
      end
      if (report_taken) begin
        progress            = 1'b1;
        it.func             = in_if.func;
        it.loss_fraction    = in_if.loss_fraction;
        it.encoder_rate     = in_if.encoder_rate;
        it.estimated_rate   = in_if.estimated_rate;
        it.sink_present     = in_if.sink_present;
        it.preset_rate      = in_if.preset_rate;
        expected_updates.push_back(predict_bitrate(it));
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // driver: bursts of requests with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : driver
    abc_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !report_taken) begin
      // hold the current request
    end else if (gap_left != 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (pending_reports.size() != 0) begin
      nxt = pending_reports.pop_front();
      in_if.valid          <= 1'b1;
      in_if.func           <= nxt.func;
      in_if.loss_fraction  <= nxt.loss_fraction;
      in_if.encoder_rate   <= nxt.encoder_rate;
      in_if.estimated_rate <= nxt.estimated_rate;
      in_if.sink_present   <= nxt.sink_present;
      in_if.preset_rate    <= nxt.preset_rate;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 12);
        end else begin
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        end
      end else begin
        burst_left--;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver: stall pattern switches mode every so often
  sink_mode_e  sink_mode  = SinkOpen;
  int unsigned sink_left  = 0;
  int unsigned sink_tick  = 0;

  always @(negedge clk_i) begin : receiver
    logic rdy;
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(10, 120);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SinkOpen:   rdy = 1'b1;
      SinkCoin:   rdy = 1'($urandom_range(0, 1));
      SinkSparse: rdy = ($urandom_range(0, 3) == 0);
      default:    rdy = (sink_tick % 5) >= 2;
    endcase
    out_if.ready <= rdy;
  end

  // random request of the given kind, fields spread over their ranges
  function automatic abc_item_t make_item(input logic [FuncW-1:0] fn,
                                          input logic [LossW-1:0] loss);
    abc_item_t        it;
    logic [RateW+1:0] knee;
    logic [RateW-1:0] a;
    logic [RateW-1:0] b;
    it.func           = fn;
    it.loss_fraction  = loss;
    it.estimated_rate = ($urandom_range(0, 3) == 0) ? RateW'($urandom)
                                                    : RateW'($urandom_range(0, 9000));
    case ($urandom_range(0, 2))
      0: begin
        // right at the 1.5x boundary
        knee = (RateW+2)'(({2'b0, it.estimated_rate} * 3 + 1) >> 1);
        if ($urandom_range(0, 1) == 0 && knee != 0) begin
          knee = knee - 1'b1;
        end
        it.encoder_rate = (knee > {2'b0, RateAll}) ? RateW'($urandom) : knee[RateW-1:0];
      end
      1: it.encoder_rate = RateW'($urandom);
      default: it.encoder_rate = RateW'($urandom_range(0, 12000));
    endcase
    it.sink_present = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1) == 0) begin
      it.preset_rate = RateW'($urandom);
    end else begin
      a = $urandom_range(0, 1) ? rate_reg[CfgSteadyMin] : rate_reg[CfgCongestMin];
      b = $urandom_range(0, 1) ? rate_reg[CfgSteadyMax] : rate_reg[CfgCongestMax];
      it.preset_rate = RateW'($urandom_range(a, b));
    end
    return it;
  endfunction

  function automatic abc_item_t fixed_report(input logic [LossW-1:0] loss, input logic sink,
                                             input logic [RateW-1:0] enc,
                                             input logic [RateW-1:0] est);
    abc_item_t it;
    it                = make_item(FuncReport, loss);
    it.sink_present   = sink;
    it.encoder_rate   = enc;
    it.estimated_rate = est;
    return it;
  endfunction

  function automatic abc_item_t preset_req(input logic [FuncW-1:0] fn,
                                           input logic [RateW-1:0] rate);
    abc_item_t it;
    it             = make_item(fn, LossW'($urandom));
    it.preset_rate = rate;
    return it;
  endfunction

  task automatic queue_item(input abc_item_t it);
    pending_reports.push_back(it);
    queued++;
  endtask

  // a run of clean reports ended by a loss, a lone loss, a preset, an unused code, or noise
  task automatic queue_segment();
    int unsigned pick;
    abc_item_t   it;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      repeat ($urandom_range(1, 16)) queue_item(make_item(FuncReport, '0));
      queue_item(make_item(FuncReport, LossW'($urandom_range(1, 255))));
    end else if (pick < 78) begin
      queue_item(make_item(FuncReport, LossW'($urandom_range(1, 255))));
    end else if (pick < 90) begin
      queue_item(make_item($urandom_range(0, 1) ? FuncRestart : FuncFixed, LossW'($urandom)));
    end else if (pick < 94) begin
      pending_reports.push_back(make_item(FuncUnused, LossW'($urandom)));
    end else begin
      it = make_item(FuncW'($urandom_range(0, 3)), LossW'($urandom));
      it.encoder_rate   = RateW'($urandom);
      it.estimated_rate = RateW'($urandom);
      it.preset_rate    = RateW'($urandom);
      it.sink_present   = 1'($urandom_range(0, 1));
      queue_item(it);
    end
  endtask

  // wait until every request is answered and the block is quiet
  task automatic wait_drained();
    while (pending_reports.size() != 0 || in_if.valid || expected_updates.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [RateW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // write all eight registers from one limit profile
  task automatic set_limits(input limit_profile_e prof);
    logic [RateW-1:0] v [NumCfg];
    logic [RateW-1:0] hi;
    case (prof)
      LimWide: begin
        v[CfgSteadyMax]   = RateAll; v[CfgSteadyMin]   = '0;
        v[CfgSteadyUp]    = RateAll; v[CfgSteadyDown]  = RateAll;
        v[CfgCongestMax]  = RateAll; v[CfgCongestMin]  = '0;
        v[CfgCongestUp]   = RateAll; v[CfgCongestDown] = RateAll;
      end
      LimZero: begin
        for (int i = 0; i < NumCfg; i++) v[i] = '0;
      end
      LimCrossed: begin
        // min above max, no rate is ever in range
        hi = RateW'($urandom_range(1000, 50000));
        v[CfgSteadyMax]   = hi;
        v[CfgSteadyMin]   = hi + RateW'($urandom_range(1, 500));
        hi = RateW'($urandom_range(1000, 50000));
        v[CfgCongestMax]  = hi;
        v[CfgCongestMin]  = hi + RateW'($urandom_range(1, 500));
        v[CfgSteadyUp]    = RateW'($urandom_range(1, 2000));
        v[CfgSteadyDown]  = RateW'($urandom_range(1, 2000));
        v[CfgCongestUp]   = RateW'($urandom_range(1, 2000));
        v[CfgCongestDown] = RateW'($urandom_range(1, 2000));
      end
      LimDefault: begin
        for (int i = 0; i < NumCfg; i++) v[i] = CfgReset[i];
      end
      default: begin
        hi = ($urandom_range(0, 3) == 0) ? RateW'($urandom_range(1, RateAll))
                                         : RateW'($urandom_range(1, 20000));
        v[CfgSteadyMax]   = hi;
        v[CfgSteadyMin]   = RateW'($urandom_range(0, hi));
        hi = ($urandom_range(0, 3) == 0) ? RateW'($urandom_range(1, RateAll))
                                         : RateW'($urandom_range(1, 20000));
        v[CfgCongestMax]  = hi;
        v[CfgCongestMin]  = RateW'($urandom_range(0, hi));
        v[CfgSteadyUp]    = ($urandom_range(0, 3) == 0) ? RateW'($urandom)
                                                        : RateW'($urandom_range(0, 2000));
        v[CfgSteadyDown]  = ($urandom_range(0, 3) == 0) ? RateW'($urandom)
                                                        : RateW'($urandom_range(0, 2000));
        v[CfgCongestUp]   = ($urandom_range(0, 3) == 0) ? RateW'($urandom)
                                                        : RateW'($urandom_range(0, 2000));
        v[CfgCongestDown] = ($urandom_range(0, 3) == 0) ? RateW'($urandom)
                                                        : RateW'($urandom_range(0, 2000));
      end
    endcase
    for (int i = 0; i < NumCfg; i++) cfg_write(CfgIdxW'(i), v[i]);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    limit_profile_e prof;
    int unsigned    target;
    in_if.valid          = 1'b0;
    in_if.func           = FuncReport;
    in_if.loss_fraction  = '0;
    in_if.encoder_rate   = '0;
    in_if.estimated_rate = '0;
    in_if.sink_present   = 1'b0;
    in_if.preset_rate    = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    for (int i = 0; i < NumCfg; i++) rate_reg[i] = CfgReset[i];
    link_cong = 1'b0;
    lim_cong  = 1'b0;
    run_cnt   = '0;
    cur_rate  = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default limits
    queue_item(fixed_report('0, 1'b0, 20'd100, 20'd100));      // from zero, raise clamps to min
    queue_item(preset_req(FuncRestart, 20'd3000));
    queue_item(preset_req(FuncFixed, RateAll));                  // above max, kept
    queue_item(preset_req(FuncFixed, '0));                       // below min, kept
    queue_item(fixed_report('0, 1'b1, 20'd3, 20'd2));            // exactly 1.5x, warning
    queue_item(fixed_report('0, 1'b1, 20'd4, 20'd3));            // just below 1.5x
    queue_item(fixed_report('0, 1'b0, RateAll, '0));             // no sink, no check
    queue_item(fixed_report('0, 1'b1, RateAll, RateAll));
    queue_item(fixed_report('0, 1'b1, RateAll, '0));
    queue_item(fixed_report(8'hff, 1'b1, '0, RateAll));          // loss, congested
    queue_item(preset_req(FuncFixed, 20'd500));
    queue_item(fixed_report(8'h01, 1'b0, '0, '0));               // loss under congested limits, step down
    repeat (11) queue_item(fixed_report('0, 1'b0, 20'd10, 20'd1000));  // back to steady
    pending_reports.push_back(make_item(FuncUnused, 8'hff));
    wait_drained();

    // random phases, each under its own limit profile
    for (int ph = 0; ph < NumPhases; ph++) begin
      prof = (ph < 4) ? limit_profile_e'(ph) : LimRandom;
      set_limits(prof);
      if (prof == LimDefault) begin
        // long clean run saturates the run count
        queue_item(make_item(FuncReport, 8'h80));
        repeat (LongRun) queue_item(make_item(FuncReport, '0));
      end
      target = queued + PhaseItems;
      while (queued < target) queue_segment();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/abc_pkg.sv
hw/rtl/abc_if.sv
hw/rtl/abc_update.sv
hw/rtl/adaptive_bitrate_controller_unit.sv
sim/testbench.sv
